@@ hdl/cbrt_pkg.sv @@
// ----------------------------------------------------------------------------
// cbrt_pkg
// shared types and constants for the binomial-series cube root core
// ----------------------------------------------------------------------------
package cbrt_pkg;

    localparam int DEFAULT_WORD_WIDTH    = 32;
    localparam int DEFAULT_FRACTION_BITS = 30;

    // fixed field widths
    localparam int TOL_W   = 31;
    localparam int TERMS_W = 6;
    // n = 3k reaches at most 3 * 64, so eight bits hold n and its numerators
    localparam int N_W     = 8;

    localparam logic [TOL_W-1:0]   TOL_RESET       = 31'd1024;
    localparam logic [TERMS_W-1:0] MAX_TERMS_RESET = 6'd20;

    localparam logic [N_W-1:0] N_FIRST = 8'd3;
    localparam logic [N_W-1:0] N_STEP  = 8'd3;
    localparam logic [N_W-1:0] NUM_OFS_FIRST = 8'd2;
    localparam logic [N_W-1:0] NUM_OFS_LATER = 8'd4;

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_TOLERANCE = 1'b0,
        REG_MAX_TERMS = 1'b1
    } cfg_reg_t;

    // top level sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_TERM,
        ST_FINISH
    } core_state_t;

    // term unit sequencer
    typedef enum logic [1:0] {
        TU_IDLE,
        TU_MUL,
        TU_SCALE,
        TU_DIV
    } tu_state_t;

    // request from the top level sequencer to the term unit
    typedef struct packed {
        logic           start;
        logic [N_W-1:0] num;
        logic [N_W-1:0] den;
    } term_req_t;

endpackage

@@ hdl/cbrt_term_unit.sv @@
// ----------------------------------------------------------------------------
// cbrt_term_unit
// next term magnitude: floor(floor(mag * x / 2^F) * num / den), with a
// bit-serial multiply, one narrow scaling multiply and a restoring divide
// ----------------------------------------------------------------------------
module cbrt_term_unit
    import cbrt_pkg::*;
#(
    parameter int WORD_WIDTH    = DEFAULT_WORD_WIDTH,
    parameter int FRACTION_BITS = DEFAULT_FRACTION_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  term_req_t             req,
    input  logic [WORD_WIDTH-2:0] mag_in,
    input  logic [WORD_WIDTH-1:0] x_mag,
    output logic                  done,
    output logic [WORD_WIDTH-2:0] mag_out
);

    localparam int PROD_W    = 2 * WORD_WIDTH;
    localparam int DIV_W     = WORD_WIDTH - 1 + N_W;
    localparam int CNT_W     = $clog2(DIV_W + 1);
    localparam int SAT_SHIFT = FRACTION_BITS + WORD_WIDTH - 1;

    tu_state_t              state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [WORD_WIDTH-2:0]  mcand_reg, mcand_next;
    logic [WORD_WIDTH-1:0]  mplier_reg, mplier_next;
    logic [WORD_WIDTH-1:0]  hi_reg, hi_next;
    logic [WORD_WIDTH-1:0]  lo_reg, lo_next;
    logic [N_W-1:0]         num_reg, num_next;
    logic [N_W-1:0]         den_reg, den_next;
    logic [DIV_W-1:0]       quo_reg, quo_next;
    logic [N_W-1:0]         rem_reg, rem_next;
    logic                   done_reg, done_next;

    logic [WORD_WIDTH:0]    acc_sum;
    logic [PROD_W-1:0]      product;
    logic [PROD_W-1:0]      prod_shifted;
    logic                   prod_ovf;
    logic [WORD_WIDTH-2:0]  t1;
    logic [N_W:0]           trial;
    logic                   trial_ge;

    // shared datapath
    always_comb
    begin
        acc_sum      = {1'b0, hi_reg}
                     + (mplier_reg[0] ? {2'b00, mcand_reg} : '0);
        product      = {hi_reg, lo_reg};
        prod_shifted = product >> FRACTION_BITS;
        prod_ovf     = |(product >> SAT_SHIFT);
        t1           = prod_ovf ? '1 : prod_shifted[WORD_WIDTH-2:0];
        trial        = {rem_reg, quo_reg[DIV_W-1]};
        trial_ge     = (trial >= {1'b0, den_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= TU_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        hi_reg     <= hi_next;
        lo_reg     <= lo_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        hi_next     = hi_reg;
        lo_next     = lo_reg;
        num_next    = num_reg;
        den_next    = den_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        done_next   = 1'b0;

        unique case (state_reg)
            TU_IDLE:
            begin
                if (req.start)
                begin
                    mcand_next  = mag_in;
                    mplier_next = x_mag;
                    hi_next     = '0;
                    lo_next     = '0;
                    num_next    = req.num;
                    den_next    = req.den;
                    cnt_next    = CNT_W'(WORD_WIDTH - 1);
                    state_next  = TU_MUL;
                end
            end
            TU_MUL:
            begin
                // lsb-first shift-add, product builds in {hi, lo}
                hi_next     = acc_sum[WORD_WIDTH:1];
                lo_next     = {acc_sum[0], lo_reg[WORD_WIDTH-1:1]};
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = TU_SCALE;
                end
            end
            TU_SCALE:
            begin
                quo_next   = DIV_W'(t1) * DIV_W'(num_reg);
                rem_next   = '0;
                cnt_next   = CNT_W'(DIV_W - 1);
                state_next = TU_DIV;
            end
            TU_DIV:
            begin
                rem_next = trial_ge ? N_W'(trial - {1'b0, den_reg}) : trial[N_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], trial_ge};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = TU_IDLE;
                end
            end
            default:
            begin
                state_next = TU_IDLE;
            end
        endcase
    end

    assign done    = done_reg;
    // num < den keeps the quotient inside the magnitude range
    assign mag_out = quo_reg[WORD_WIDTH-2:0];

endmodule

@@ hdl/cube_root_binomial_series_core.sv @@
// ----------------------------------------------------------------------------
// cube_root_binomial_series_core
// evaluates (1 - x)^(1/3) by its binomial series in signed fixed point
// ----------------------------------------------------------------------------
// throughput: one beat at a time; the bit-serial multiply and the restoring
//   divide inside the term unit set the cost of each term
// input is taken only while the sequencer is idle; the output register lets a
//   new beat in while the last result waits
// reset: async active low, clears control and restores tolerance = 1024 and
//   max_terms = 20
// ----------------------------------------------------------------------------
module cube_root_binomial_series_core
    import cbrt_pkg::*;
#(
    parameter int WORD_WIDTH    = DEFAULT_WORD_WIDTH,
    parameter int FRACTION_BITS = DEFAULT_FRACTION_BITS
)
(
    input  logic                         clk,
    input  logic                         rst_n,

    // configuration write port
    input  logic                         cfg_write,
    input  logic [0:0]                   cfg_index,
    input  logic [TOL_W-1:0]             cfg_data,

    // input beat
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [WORD_WIDTH-1:0] x_value,

    // result beat
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [WORD_WIDTH-1:0] root_sum,
    output logic [TERMS_W-1:0]           term_count,
    output logic                         limit_hit,
    output logic                         precision_hit
);

    localparam int MAG_W = WORD_WIDTH - 1;
    localparam int CMP_W = (MAG_W > TOL_W) ? MAG_W : TOL_W;

    // 1.0, or the largest magnitude when 1.0 does not fit
    localparam logic [MAG_W-1:0] ONE_MAG = (FRACTION_BITS >= MAG_W) ? {MAG_W{1'b1}}
                                         : ({{(MAG_W-1){1'b0}}, 1'b1} << FRACTION_BITS);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [TOL_W-1:0]   tol_reg;
    logic [TERMS_W-1:0] max_terms_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg       <= TOL_RESET;
            max_terms_reg <= MAX_TERMS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_TOLERANCE: tol_reg       <= cfg_data;
                REG_MAX_TERMS: max_terms_reg <= cfg_data[TERMS_W-1:0];
                default:       tol_reg       <= tol_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // sequencer and sum state
    // ------------------------------------------------------------------
    core_state_t               state_reg, state_next;
    logic [WORD_WIDTH-1:0]     xmag_reg, xmag_next;
    logic                      xneg_reg, xneg_next;
    logic [MAG_W-1:0]          dmag_reg, dmag_next;
    logic                      dneg_reg, dneg_next;
    logic signed [WORD_WIDTH-1:0] sum_reg, sum_next;
    logic [TERMS_W-1:0]        count_reg, count_next;
    logic [N_W-1:0]            n_reg, n_next;

    // output register
    logic                      out_valid_reg, out_valid_next;
    logic signed [WORD_WIDTH-1:0] root_sum_reg, root_sum_next;
    logic [TERMS_W-1:0]        term_count_reg, term_count_next;
    logic                      limit_hit_reg, limit_hit_next;
    logic                      precision_hit_reg, precision_hit_next;

    term_req_t                 tu_req;
    logic                      tu_done;
    logic [MAG_W-1:0]          tu_mag;

    logic                      in_beat;
    logic                      out_free;
    logic                      new_neg;
    logic signed [WORD_WIDTH:0] sum_wide;
    logic signed [WORD_WIDTH-1:0] sum_sat;
    logic                      new_below_tol;
    logic                      cur_below_tol;

    assign in_beat  = in_valid && (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    // sign and saturating sum update for the term coming out of the unit
    always_comb
    begin
        new_neg = (tu_mag != '0) && (dneg_reg != xneg_reg);
        if (new_neg)
        begin
            sum_wide = {sum_reg[WORD_WIDTH-1], sum_reg} + {2'b00, tu_mag};
        end
        else
        begin
            sum_wide = {sum_reg[WORD_WIDTH-1], sum_reg} - {2'b00, tu_mag};
        end
        // overflow when the two top bits disagree, clamp by the true sign
        if (sum_wide[WORD_WIDTH] != sum_wide[WORD_WIDTH-1])
        begin
            sum_sat = sum_wide[WORD_WIDTH] ? {1'b1, {MAG_W{1'b0}}} : {1'b0, {MAG_W{1'b1}}};
        end
        else
        begin
            sum_sat = sum_wide[WORD_WIDTH-1:0];
        end
        new_below_tol = CMP_W'(tu_mag) < CMP_W'(tol_reg);
        cur_below_tol = CMP_W'(dmag_reg) < CMP_W'(tol_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        xmag_reg          <= xmag_next;
        xneg_reg          <= xneg_next;
        dmag_reg          <= dmag_next;
        dneg_reg          <= dneg_next;
        sum_reg           <= sum_next;
        count_reg         <= count_next;
        n_reg             <= n_next;
        root_sum_reg      <= root_sum_next;
        term_count_reg    <= term_count_next;
        limit_hit_reg     <= limit_hit_next;
        precision_hit_reg <= precision_hit_next;
    end

    always_comb
    begin
        state_next         = state_reg;
        xmag_next          = xmag_reg;
        xneg_next          = xneg_reg;
        dmag_next          = dmag_reg;
        dneg_next          = dneg_reg;
        sum_next           = sum_reg;
        count_next         = count_reg;
        n_next             = n_reg;
        root_sum_next      = root_sum_reg;
        term_count_next    = term_count_reg;
        limit_hit_next     = limit_hit_reg;
        precision_hit_next = precision_hit_reg;
        out_valid_next     = out_valid_reg && out_stall;
        tu_req             = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    // magnitude of x; the most negative word gives 2^(W-1)
                    xneg_next  = x_value[WORD_WIDTH-1];
                    xmag_next  = x_value[WORD_WIDTH-1] ? (~x_value + 1'b1) : x_value;
                    dmag_next  = ONE_MAG;
                    dneg_next  = 1'b0;
                    sum_next   = {1'b0, ONE_MAG};
                    count_next = '0;
                    n_next     = N_FIRST;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (count_reg == max_terms_reg)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    // first step scales by (n-2)/n, later ones by (n-4)/n
                    tu_req.start = 1'b1;
                    tu_req.num   = (n_reg == N_FIRST) ? (n_reg - NUM_OFS_FIRST)
                                                      : (n_reg - NUM_OFS_LATER);
                    tu_req.den   = n_reg;
                    state_next   = ST_TERM;
                end
            end
            ST_TERM:
            begin
                if (tu_done)
                begin
                    dmag_next  = tu_mag;
                    dneg_next  = new_neg;
                    sum_next   = sum_sat;
                    count_next = count_reg + 1'b1;
                    n_next     = n_reg + N_STEP;
                    state_next = new_below_tol ? ST_FINISH : ST_CHECK;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    root_sum_next      = sum_reg;
                    term_count_next    = count_reg;
                    limit_hit_next     = (count_reg == max_terms_reg);
                    precision_hit_next = cur_below_tol;
                    out_valid_next     = 1'b1;
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // term unit: shared multiply / scale / divide engine
    // ------------------------------------------------------------------
    cbrt_term_unit #(
        .WORD_WIDTH    (WORD_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_term (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (tu_req),
        .mag_in  (dmag_reg),
        .x_mag   (xmag_reg),
        .done    (tu_done),
        .mag_out (tu_mag)
    );

    // ------------------------------------------------------------------
    // ports
    // ------------------------------------------------------------------
    assign in_stall      = (state_reg != ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign root_sum      = root_sum_reg;
    assign term_count    = term_count_reg;
    assign limit_hit     = limit_hit_reg;
    assign precision_hit = precision_hit_reg;

`ifndef SYNTHESIS
    // the term unit only answers while the sequencer is in the term wait state
    a_done_in_term: assert property (@(posedge clk) disable iff (!rst_n)
        tu_done |-> (state_reg == ST_TERM))
        else $error("term unit done outside term wait");

    // a new result beat is only loaded from the finish state
    a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result beat loaded outside finish");

    // a request is never issued while the unit is still busy
    a_req_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        tu_req.start |-> (state_reg == ST_CHECK) && !tu_done)
        else $error("term request while unit busy");
`endif

endmodule
